// ----- rtl/ph_trimmed_mean_sampler_core_defines.svh -----
// Assertion helpers for the top-level core. The enclosing module must have clk and rst.
`ifndef PH_TRIMMED_MEAN_SAMPLER_CORE_DEFINES_SVH
`define PH_TRIMMED_MEAN_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PTMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ptms_pkg.sv -----
`timescale 1ns / 1ps
package ptms_pkg;

  localparam int SAMPLE_COUNT_DEF = 32;

  localparam int ADC_W      = 12;
  localparam int ADC_MAX    = 4095;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 16;
  localparam int SLOPE_W    = 20;
  localparam int OFFSET_W   = 20;
  localparam int PH_W       = 22;
  localparam int VOLT_W     = 18;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // 3.54 V full scale over 4096 codes, in Q16: 56.64 = 5664 / 100.
  localparam int VOLT_NUM   = 5664;
  localparam int VOLT_DEN   = 100;

  localparam int PH_MAX_OUT = 2097151;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd20;
  localparam logic [SLOPE_W-1:0]    SLOPE_RST    = 20'd268698;
  localparam logic [OFFSET_W-1:0]   OFFSET_RST   = 20'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

  typedef struct packed {
    logic [ADC_W-1:0]  adc_sample;
    logic [TIME_W-1:0] now_ms;
  } ptms_in_t;

  typedef struct packed {
    logic signed [PH_W-1:0] ph_level;
    logic [VOLT_W-1:0]      probe_voltage;
    logic                   sampled;
  } ptms_out_t;

  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic trim;
    logic mul1;
    logic mul2;
    logic finish;
    logic load_out;
  } ptms_cmd_t;

  typedef struct packed {
    logic take;
    logic scan_last;
    logic out_free;
  } ptms_status_t;

endpackage

// ----- rtl/ptms_ram.sv -----
`timescale 1ns / 1ps
module ptms_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/ptms_div.sv -----
`timescale 1ns / 1ps
module ptms_div #(
  parameter int DEND_W = 17,
  parameter int Q_W    = 18,
  parameter int NUM    = 5664,
  parameter int DEN    = 3000
) (
  input  logic              clk,
  input  logic              load,
  input  logic [DEND_W-1:0] dividend,
  output logic [Q_W-1:0]    quotient
);

  // floor(dividend * NUM / DEN) as one multiply by a rounded-up reciprocal.
  // The rounding error of RECIP is below DEN, so the quotient is exact as long
  // as dividend * DEN stays below 2^SHIFT, which holds for ring sizes up to 74 entries.
  localparam int     SHIFT   = 31;
  localparam longint SCALED  = longint'(NUM) << SHIFT;
  localparam longint RECIP   = (SCALED + longint'(DEN) - 1) / longint'(DEN);
  localparam int     RECIP_W = $clog2(RECIP + 1);
  localparam int     PROD_W  = DEND_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(dividend) * PROD_W'(RECIP_C);
    end
  end

  assign quotient = prod[SHIFT +: Q_W];

endmodule

// ----- rtl/ptms_ctrl.sv -----
`timescale 1ns / 1ps
module ptms_ctrl
  import ptms_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  ptms_status_t status,
  output ptms_cmd_t    cmd,
  output logic         in_stall
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_TAIL, S_TRIM, S_MUL1, S_MUL2, S_FIN, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.take ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: state_next = S_TRIM;
      S_TRIM: begin
        cmd.trim   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ----- rtl/ptms_datapath.sv -----
`timescale 1ns / 1ps
module ptms_datapath
  import ptms_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ptms_in_t              in_item,
  input  logic                  out_stall,
  input  ptms_cmd_t             cmd,
  output ptms_status_t          status,
  output logic                  out_valid,
  output ptms_out_t             out_item
);

  localparam int ADDR_W  = $clog2(SAMPLE_COUNT);
  localparam int SUM_W   = $clog2(SAMPLE_COUNT * ADC_MAX + 1);
  localparam int DIVISOR = VOLT_DEN * (SAMPLE_COUNT - 2);
  localparam int MUL2_W  = SLOPE_W + VOLT_W;
  localparam logic signed [PH_W+1:0] PH_SAT = (PH_W + 2)'(PH_MAX_OUT);

  logic [INTERVAL_W-1:0]    interval;
  logic [SLOPE_W-1:0]       slope;
  logic signed [OFFSET_W-1:0] offset;

  logic [TIME_W-1:0]        last_time;
  logic [TIME_W-1:0]        elapsed;
  logic [ADDR_W-1:0]        pos;
  logic [SAMPLE_COUNT-1:0]  ent_valid;
  logic                     did;

  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_pend;
  logic                     rd_vld_q;
  logic [ADC_W-1:0]         rdata;
  logic [ADC_W-1:0]         rval;

  logic [SUM_W-1:0]         sum;
  logic [ADC_W-1:0]         mn;
  logic [ADC_W-1:0]         mx;
  logic [SUM_W-1:0]         trimmed;
  logic [VOLT_W-1:0]        quot;
  logic [MUL2_W-1:0]        prod2;
  logic signed [PH_W+1:0]   ph_sum;

  logic signed [PH_W-1:0]   held_ph;
  logic [VOLT_W-1:0]        held_volt;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RST;
      slope    <= SLOPE_RST;
      offset   <= OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INTERVAL: interval <= cfg_data[INTERVAL_W-1:0];
        CFG_SLOPE:    slope    <= cfg_data[SLOPE_W-1:0];
        CFG_OFFSET:   offset   <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign elapsed     = in_item.now_ms - last_time;
  assign status.take = elapsed > TIME_W'(interval);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      pos       <= '0;
      ent_valid <= '0;
      did       <= 1'b0;
    end else if (cmd.accept) begin
      did <= status.take;
      if (status.take) begin
        last_time      <= in_item.now_ms;
        ent_valid[pos] <= 1'b1;
        if (pos == ADDR_W'(SAMPLE_COUNT - 1)) begin
          pos <= '0;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  ptms_ram #(
    .WIDTH (ADC_W),
    .DEPTH (SAMPLE_COUNT)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept && status.take),
    .waddr (pos),
    .wdata (in_item.adc_sample),
    .re    (cmd.scan_rd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr  <= '0;
      rd_pend  <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_rd;
      if (cmd.accept) begin
        rd_addr <= '0;
      end else if (cmd.scan_rd) begin
        rd_addr  <= rd_addr + 1'b1;
        rd_vld_q <= ent_valid[rd_addr];
      end
    end
  end

  assign status.scan_last = (rd_addr == ADDR_W'(SAMPLE_COUNT - 1));
  assign rval             = rd_vld_q ? rdata : '0;

  // Sum of all entries less one minimum and one maximum.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum <= '0;
      mn  <= '1;
      mx  <= '0;
    end else if (rd_pend) begin
      sum <= sum + SUM_W'(rval);
      if (rval < mn) begin
        mn <= rval;
      end
      if (rval > mx) begin
        mx <= rval;
      end
    end
    if (cmd.trim) begin
      trimmed <= sum - SUM_W'(mn) - SUM_W'(mx);
    end
    if (cmd.mul2) begin
      prod2 <= MUL2_W'(slope) * MUL2_W'(quot);
    end
  end

  ptms_div #(
    .DEND_W (SUM_W),
    .Q_W    (VOLT_W),
    .NUM    (VOLT_NUM),
    .DEN    (DIVISOR)
  ) u_div (
    .clk      (clk),
    .load     (cmd.mul1),
    .dividend (trimmed),
    .quotient (quot)
  );

  assign ph_sum = $signed({2'b00, prod2[MUL2_W-1:FRAC_W]})
                + $signed({{(PH_W + 2 - OFFSET_W){offset[OFFSET_W-1]}}, offset});

  always_ff @(posedge clk) begin
    if (rst) begin
      held_ph   <= '0;
      held_volt <= '0;
    end else if (cmd.finish) begin
      held_volt <= quot;
      if (ph_sum > PH_SAT) begin
        held_ph <= PH_SAT[PH_W-1:0];
      end else begin
        held_ph <= ph_sum[PH_W-1:0];
      end
    end
  end

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_item <= '{ph_level: held_ph, probe_voltage: held_volt, sampled: did};
    end
  end

endmodule

// ----- rtl/ph_trimmed_mean_sampler_core.sv -----
`timescale 1ns / 1ps
// Timed pH probe sampler with a min/max trimmed mean of the last SAMPLE_COUNT readings.
// Input channel sample_*: one item carries a converter reading and a millisecond time.
// Every accepted item gives exactly one result item on result_*: the held pH and
// probe voltage, and a flag telling whether this item stored a new sample.
// An item whose elapsed time does not exceed the interval leaves the ring and sample time alone;
// its result is loaded into the output register from state DONE once that register is free.
// A stored sample walks the ring memory one entry a cycle (read port of the ring),
// then scales the trimmed sum to volts with a multiply by a constant reciprocal,
// applies the slope and adds the offset, saturating the pH at PH_MAX_OUT; then loads its result.
// sample_stall stays high until the result has been placed in the output register,
// so one item is in work at a time.
// While result_stall holds a result, the next item may still be taken and worked on,
// but its result waits (and sample_stall stays high) until the output register frees.
// Configuration writes on cfg_* are always ready and belong to idle periods.
// Reset (synchronous) loads the register defaults, clears the ring to zero through
// per-entry valid bits, and zeroes the held values and the sample time.
module ph_trimmed_mean_sampler_core
  import ptms_pkg::*;
#(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  ptms_in_t              sample_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output ptms_out_t             result_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "ph_trimmed_mean_sampler_core_defines.svh"

  ptms_cmd_t    cmd;
  ptms_status_t status;

  assign cfg_ready = 1'b1;

  ptms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (sample_stall)
  );

  ptms_datapath #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (sample_item),
    .out_stall (result_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (result_valid),
    .out_item  (result_item)
  );

  `PTMS_ASSERT_NXT(a_one_in_flight, sample_valid && !sample_stall, sample_stall, "item accepted while busy")
  `PTMS_ASSERT_IMP(a_load_when_free, cmd.load_out, !result_valid || !result_stall, "result overwritten")
  `PTMS_ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0(cmd), "overlapping datapath commands")
  `PTMS_ASSERT_IMP(a_result_source, $rose(result_valid), $past(cmd.load_out), "result without load")

endmodule
